@@ hw/rtl/scancode_line_editor_defines.svh @@
// assertion macros shared by the checker
`ifndef SCANCODE_LINE_EDITOR_DEFINES_SVH
`define SCANCODE_LINE_EDITOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SCLE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SCLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/scle_pkg.sv @@
package scle_pkg;

	// scan codes with a fixed meaning
	localparam logic [7:0] SC_LSHIFT     = 8'h2A;
	localparam logic [7:0] SC_RSHIFT     = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
	localparam logic [7:0] SC_CAPS       = 8'h3A;

	// ascii codes with a special role
	localparam logic [6:0] CH_NONE  = 7'h00;
	localparam logic [6:0] CH_BACK  = 7'h08;
	localparam logic [6:0] CH_ENTER = 7'h0A;

	// event kinds
	localparam logic [1:0] EV_STORE = 2'd0;
	localparam logic [1:0] EV_ERASE = 2'd1;
	localparam logic [1:0] EV_END   = 2'd2;

	localparam logic [8:0] CAP_RESET = 9'd256;
	localparam int TABLE_LEN = 58;

	localparam logic [6:0] LOWER_MAP [TABLE_LEN] = '{
		7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20
	};

	localparam logic [6:0] UPPER_MAP [TABLE_LEN] = '{
		7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20
	};

	typedef struct packed {
		logic [1:0] event_kind;
		logic [6:0] char_code;
		logic [7:0] position;
		logic [7:0] line_length;
		logic       last;
	} result_t;

	typedef struct packed {
		logic       shift_held;
		logic       caps_on;
		logic [7:0] char_count;
	} edit_state_t;

	typedef struct packed {
		logic [1:0]  n_res;
		result_t     res0;
		result_t     res1;
		edit_state_t nxt;
	} decode_t;

	// character for a make code, zero past the tables
	function automatic logic [6:0] map_char(input logic [6:0] idx, input logic upper);
		logic [6:0] ch;
		ch = CH_NONE;
		if (int'(idx) < TABLE_LEN) begin
			ch = upper ? UPPER_MAP[idx[5:0]] : LOWER_MAP[idx[5:0]];
		end
		return ch;
	endfunction

	// characters per line, capacity clamped to 2..256
	function automatic logic [7:0] char_limit(input logic [8:0] cap);
		logic [7:0] lim;
		if (cap < 9'd2) begin
			lim = 8'd1;
		end else if (cap > 9'd256) begin
			lim = 8'd255;
		end else begin
			lim = 8'(cap - 9'd1);
		end
		return lim;
	endfunction

endpackage

@@ hw/rtl/scle_if.sv @@
// scan code channel
interface scle_scan_if;
	logic       valid;
	logic       ready;
	logic [7:0] scan_code;

	modport source (output valid, output scan_code, input ready);
	modport sink (input valid, input scan_code, output ready);
endinterface

// editor event channel
interface scle_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_kind;
	logic [6:0] char_code;
	logic [7:0] position;
	logic [7:0] line_length;
	logic       last;

	modport source (output valid, output event_kind, output char_code, output position,
		output line_length, output last, input ready);
	modport sink (input valid, input event_kind, input char_code, input position,
		input line_length, input last, output ready);
endinterface

// line capacity write channel
interface scle_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] line_capacity;

	modport source (output valid, output line_capacity, input ready);
	modport sink (input valid, input line_capacity, output ready);
endinterface

@@ hw/rtl/scle_decode.sv @@
module scle_decode #(
	parameter int TABLE_ENTRIES = 58
) (
	input  logic [7:0]            scan_code,
	input  scle_pkg::edit_state_t cur,
	input  logic [8:0]            line_capacity,
	output scle_pkg::decode_t     dec
);
	import scle_pkg::*;

	logic [6:0] ch;
	logic       in_table;
	logic [7:0] lim;
	logic [7:0] cnt_inc;
	logic [7:0] cnt_dec;

	// table lookup and line limit
	assign ch       = map_char(scan_code[6:0], cur.shift_held ^ cur.caps_on);
	assign in_table = !scan_code[7] && (int'(scan_code) < TABLE_ENTRIES);
	assign lim      = char_limit(line_capacity);
	assign cnt_inc  = cur.char_count + 8'd1;
	assign cnt_dec  = cur.char_count - 8'd1;

	// modifier handling and editing action
	always_comb begin
		dec       = '0;
		dec.nxt   = cur;
		priority if (scan_code == SC_LSHIFT || scan_code == SC_RSHIFT) begin
			dec.nxt.shift_held = 1'b1;
		end else if (scan_code == SC_LSHIFT_BRK || scan_code == SC_RSHIFT_BRK) begin
			dec.nxt.shift_held = 1'b0;
		end else if (scan_code == SC_CAPS) begin
			dec.nxt.caps_on = !cur.caps_on;
		end else if (!in_table || ch == CH_NONE) begin
			dec.n_res = 2'd0;
		end else if (ch == CH_ENTER) begin
			dec.n_res = 2'd1;
			dec.res0  = '{EV_END, CH_NONE, 8'd0, cur.char_count, 1'b1};
			dec.nxt   = '0;
		end else if (ch == CH_BACK) begin
			if (cur.char_count != 8'd0) begin
				dec.n_res          = 2'd1;
				dec.res0           = '{EV_ERASE, CH_NONE, cnt_dec, cnt_dec, 1'b1};
				dec.nxt.char_count = cnt_dec;
			end
		end else if (cnt_inc >= lim) begin
			// store fills the line, line end follows
			dec.n_res = 2'd2;
			dec.res0  = '{EV_STORE, ch, cur.char_count, cnt_inc, 1'b0};
			dec.res1  = '{EV_END, CH_NONE, 8'd0, cnt_inc, 1'b1};
			dec.nxt   = '0;
		end else begin
			dec.n_res          = 2'd1;
			dec.res0           = '{EV_STORE, ch, cur.char_count, cnt_inc, 1'b1};
			dec.nxt.char_count = cnt_inc;
		end
	end

endmodule

@@ hw/rtl/scle_result_queue.sv @@
module scle_result_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [1:0]        n_res,
	input  scle_pkg::result_t res0,
	input  scle_pkg::result_t res1,
	input  logic              pop,
	output logic              can_take,
	output logic              out_valid,
	output scle_pkg::result_t out_res
);
	import scle_pkg::*;

	result_t    ent0_q;
	result_t    ent1_q;
	logic [1:0] cnt_q;

	// room for a full pair once this cycle's pop is done
	assign can_take  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
	assign out_valid = (cnt_q != 2'd0);
	assign out_res   = ent0_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push) begin
			cnt_q <= n_res;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// entries, head at ent0
	always_ff @(posedge clk) begin
		if (push) begin
			ent0_q <= res0;
			ent1_q <= res1;
		end else if (pop) begin
			ent0_q <= ent1_q;
		end
	end

endmodule

@@ hw/rtl/scancode_line_editor.sv @@
// Line editor fed by PS/2 scan code set 1 bytes.
// Channels: scan takes one scan code per transaction; result gives editor
// events (character stored, character erased, line ended), each with the
// buffer position and line length; cfg writes line_capacity, which is
// always ready and must only be written while the block is idle.
// Throughput: one scan code per cycle while each code yields at most one
// event and result does not stall. A code that fills the line yields a
// store and a line end into the two-entry result queue, so a code with an
// event right behind it waits in the input register until the line end pops.
// An event reaches result through the input register, then decode into the
// result queue.
// Codes that only change modifiers or carry no character give no event.
// Reset clears shift, caps, the character count and the result queue, and
// sets line_capacity to 256.
// When result stalls, its head event holds; scan stays ready until the input
// register holds a code with an event that the queue cannot take.
module scancode_line_editor #(
	parameter int TABLE_ENTRIES = 58
) (
	input  logic                 clk,
	input  logic                 arst_n,
	scle_scan_if.sink            scan,
	scle_result_if.source        result,
	scle_cfg_if.sink             cfg
);
	import scle_pkg::*;

	logic [7:0]  code_s1;
	logic        valid_s1;
	edit_state_t st_q;
	logic [8:0]  cap_q;
	decode_t     dec;
	logic        can_take;
	logic        advance;
	logic        push;
	logic        pop;
	logic        out_valid;
	result_t     out_res;

	// input register
	assign advance    = valid_s1 && (can_take || dec.n_res == 2'd0);
	assign push       = advance && (dec.n_res != 2'd0);
	assign scan.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			code_s1 <= scan.scan_code;
		end
	end

	// editor state, updated as each code leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= dec.nxt;
		end
	end

	// capacity register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.line_capacity;
		end
	end

	scle_decode #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_decode (
		.scan_code    (code_s1),
		.cur          (st_q),
		.line_capacity(cap_q),
		.dec          (dec)
	);

	// result queue and output channel
	assign pop = out_valid && result.ready;

	scle_result_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.n_res    (dec.n_res),
		.res0     (dec.res0),
		.res1     (dec.res1),
		.pop      (pop),
		.can_take (can_take),
		.out_valid(out_valid),
		.out_res  (out_res)
	);

	assign result.valid       = out_valid;
	assign result.event_kind  = out_res.event_kind;
	assign result.char_code   = out_res.char_code;
	assign result.position    = out_res.position;
	assign result.line_length = out_res.line_length;
	assign result.last        = out_res.last;

endmodule

@@ hw/rtl/scle_checker.sv @@
`include "scancode_line_editor_defines.svh"

module scle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] event_kind,
	input logic [6:0] char_code,
	input logic [7:0] position,
	input logic [7:0] line_length,
	input logic       last
);
	import scle_pkg::*;

	// stalled event holds
	`SCLE_ASSERT_NEXT(a_stall_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(event_kind) && $stable(char_code) && $stable(position) && $stable(line_length) && $stable(last), "event changed while stalled")

	// erase reports the new length as its position
	`SCLE_ASSERT_SAME(a_erase_fields, clk, arst_n, res_valid && event_kind == EV_ERASE, position == line_length && char_code == 7'd0 && last, "bad erase event")

	// store leaves the line one past its position
	`SCLE_ASSERT_SAME(a_store_len, clk, arst_n, res_valid && event_kind == EV_STORE, line_length == position + 8'd1, "store length mismatch")

	// line end carries no character and closes the transaction
	`SCLE_ASSERT_SAME(a_end_fields, clk, arst_n, res_valid && event_kind == EV_END, char_code == 7'd0 && position == 8'd0 && last, "bad line end event")

	// a store that is not last is followed at once by the line end
	`SCLE_ASSERT_NEXT(a_fill_end, clk, arst_n, res_valid && res_ready && event_kind == EV_STORE && !last, res_valid && event_kind == EV_END, "line end missing after full store")

endmodule

bind scancode_line_editor scle_checker u_scle_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.event_kind (result.event_kind),
	.char_code  (result.char_code),
	.position   (result.position),
	.line_length(result.line_length),
	.last       (result.last)
);
